// ===== rtl/core/ldfs_pkg.sv =====
package ldfs_pkg;

	// command codes
	localparam logic [2:0] OP_TICK        = 3'd0;
	localparam logic [2:0] OP_SET_LEVEL   = 3'd1;
	localparam logic [2:0] OP_FADE        = 3'd2;
	localparam logic [2:0] OP_ON          = 3'd3;
	localparam logic [2:0] OP_OFF         = 3'd4;
	localparam logic [2:0] OP_STROBE      = 3'd5;
	localparam logic [2:0] OP_STOP_STROBE = 3'd6;
	localparam logic [2:0] OP_STOP_FADE   = 3'd7;

	// divider sizes: for a fade step the dividend is 2*mag*elapsed + remaining, divisor 2*remaining
	localparam int DIVD_W = 26;
	localparam int DIVS_W = 17;
	localparam int CNT_W  = 5;

	localparam logic [6:0] PCT_FULL  = 7'd100;
	localparam logic [7:0] LEVEL_MAX = 8'd255;

	// x / 100 as (x * 5243) >> 19, exact for x up to 25500
	localparam logic [12:0] RECIP_100 = 13'd5243;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quotient;
	} div_rsp_t;

endpackage

// ===== rtl/core/ldfs_div.sv =====
module ldfs_div
	import ldfs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W:0]   rem_q;
	logic [DIVS_W-1:0] dvs_q;
	logic              done_q;
	logic [DIVS_W:0]   trial;
	logic [DIVS_W+1:0] diff;

	// one restoring step per cycle
	assign trial = {rem_q[DIVS_W-1:0], quo_q[DIVD_W-1]};
	assign diff  = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[DIVS_W+1]) begin
				rem_q <= diff[DIVS_W:0];
				quo_q <= {quo_q[DIVD_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

// ===== rtl/core/led_dimmer_fade_strobe_core.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | op, level, duration, on_time, off_time,
//         |     |                     | repeat_count
// out     | out | out_valid/out_ready | pwm_level, lamp_on, brightness, fading,
//         |     |                     | onoff_fading, strobing
// cfg     | in  | cfg_valid/cfg_ready | cfg_data (invert_output)
// a command runs from accept back to idle before the next one is taken; a fade or on/off
// fade start divides for the step length, and a tick may run a brightness and a percent
// fade step; fade starts and steps share one 26-step serial divider
// arst_n clears all lamp state and the invert flag
// in_ready is high only while the sequencer is idle; a finished result waits in the
// output register, and the sequencer stalls before its last step until that is taken
module led_dimmer_fade_strobe_core
	import ldfs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  op,
	input  logic [7:0]  level,
	input  logic [15:0] duration,
	input  logic [15:0] on_time,
	input  logic [15:0] off_time,
	input  logic [15:0] repeat_count,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  pwm_level,
	output logic        lamp_on,
	output logic [7:0]  brightness,
	output logic        fading,
	output logic        onoff_fading,
	output logic        strobing,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_CMD, ST_STEP_WAIT, ST_FADE_CHK, ST_FADE_GO, ST_FADE_WAIT,
		ST_STROBE, ST_PCT_CHK, ST_PCT_GO, ST_PCT_WAIT, ST_OUT_MUL, ST_OUT_GO,
		ST_OUT_PUT
	} state_t;

	state_t      state_q;
	logic        invert_q;
	logic [2:0]  op_q;
	logic [7:0]  lvl_q;
	logic [15:0] dur_q, hi_q, lo_q, rep_q;
	logic        step_pct_q;

	logic [7:0]  base_q, ftgt_q;
	logic        on_q;
	logic [15:0] frem_q, fel_q, fstep_q;
	logic [6:0]  plev_q, ptgt_q;
	logic [15:0] prem_q, pel_q, pstep_q;
	logic        sact_q, srest_q;
	logic [16:0] sel_q;
	logic [15:0] shi_q, slo_q, sleft_q;

	logic [23:0] prod_q;
	logic [7:0]  res_q;
	logic        out_valid_q;
	logic [7:0]  pwm_q, bright_q;
	logic        lamp_q, fading_q, ofad_q, strb_q;

	div_req_t    dreq;
	div_rsp_t    drsp;

	logic [7:0]  fmag, pmag, cmd_fmag, cmd_pmag;
	logic [7:0]  fnew, pnew8;
	logic [16:0] shilo;
	logic [27:0] scaled;

	ldfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	// fade magnitudes
	assign fmag     = (ftgt_q >= base_q) ? ftgt_q - base_q : base_q - ftgt_q;
	assign pmag     = {1'b0, (ptgt_q >= plev_q) ? ptgt_q - plev_q : plev_q - ptgt_q};
	assign cmd_fmag = (lvl_q >= base_q) ? lvl_q - base_q : base_q - lvl_q;
	assign shilo    = {1'b0, shi_q} + {1'b0, slo_q};

	// level scaling by 100 through a reciprocal multiply
	assign scaled   = 28'(prod_q[14:0]) * 28'(RECIP_100);

	// apply a rounded fade step, clamped to 0..top
	function automatic logic [7:0] fade_apply(input logic [7:0] cur, input logic [7:0] tgt,
			input logic [DIVD_W-1:0] inc, input logic [7:0] top);
		logic [DIVD_W:0] sum;
		begin
			sum = {1'b0, inc} + (DIVD_W+1)'(cur);
			if (tgt >= cur)
				fade_apply = (sum > (DIVD_W+1)'(top)) ? top : sum[7:0];
			else
				fade_apply = (inc > DIVD_W'(cur)) ? 8'd0 : cur - inc[7:0];
		end
	endfunction

	assign fnew  = fade_apply(base_q, ftgt_q, drsp.quotient, LEVEL_MAX);
	assign pnew8 = fade_apply({1'b0, plev_q}, {1'b0, ptgt_q}, drsp.quotient, {1'b0, PCT_FULL});
	assign cmd_pmag = {1'b0, (op_q == OP_ON) ? PCT_FULL - plev_q : plev_q};

	// divider launch
	always_comb begin
		dreq.start    = 1'b0;
		dreq.dividend = DIVD_W'(dur_q);
		dreq.divisor  = DIVS_W'(op_q == OP_FADE ? cmd_fmag : cmd_pmag);
		case (state_q)
			ST_CMD: begin
				if (op_q == OP_FADE)
					dreq.start = (dur_q != '0) && (cmd_fmag != '0);
				else if (op_q == OP_ON || op_q == OP_OFF)
					dreq.start = (dur_q != '0) && (cmd_pmag != '0);
			end
			ST_FADE_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = {1'b0, prod_q, 1'b0} + DIVD_W'(frem_q);
				dreq.divisor  = {frem_q, 1'b0};
			end
			ST_PCT_GO: begin
				dreq.start    = 1'b1;
				dreq.dividend = {1'b0, prod_q, 1'b0} + DIVD_W'(prem_q);
				dreq.divisor  = {prem_q, 1'b0};
			end
			default: ;
		endcase
	end

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			invert_q <= 1'b0;
		else if (cfg_valid)
			invert_q <= cfg_data;
	end

	assign in_ready = (state_q == ST_IDLE);

	// sequencer and lamp state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			base_q <= '0; on_q <= 1'b0; ftgt_q <= '0;
			frem_q <= '0; fel_q <= '0; fstep_q <= '0;
			plev_q <= '0; ptgt_q <= '0; prem_q <= '0; pel_q <= '0; pstep_q <= '0;
			sact_q <= 1'b0; srest_q <= 1'b0; sel_q <= '0;
			shi_q <= '0; slo_q <= '0; sleft_q <= '0;
			out_valid_q <= 1'b0;
			step_pct_q  <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_CMD;
				end
				ST_CMD: begin
					state_q <= ST_OUT_MUL;
					case (op_q)
						OP_TICK: begin
							if (frem_q != '0 && fel_q != 16'hFFFF) fel_q <= fel_q + 1'b1;
							if (sact_q && sel_q != 17'h1FFFF) sel_q <= sel_q + 1'b1;
							if (prem_q != '0 && pel_q != 16'hFFFF) pel_q <= pel_q + 1'b1;
							state_q <= ST_FADE_CHK;
						end
						OP_SET_LEVEL: begin
							frem_q <= '0;
							base_q <= lvl_q;
						end
						OP_FADE: begin
							if (dur_q == '0) begin
								frem_q <= '0;
								base_q <= lvl_q;
							end else begin
								fel_q  <= '0;
								ftgt_q <= lvl_q;
								if (cmd_fmag == '0) begin
									frem_q <= '0;
								end else begin
									frem_q     <= dur_q;
									step_pct_q <= 1'b0;
									state_q    <= ST_STEP_WAIT;
								end
							end
						end
						OP_ON, OP_OFF: begin
							if (sact_q) begin
								srest_q <= 1'b1;
								sact_q  <= 1'b0;
								sleft_q <= '0;
							end
							if (op_q == OP_ON || sact_q)
								on_q <= 1'b1;
							if (dur_q == '0) begin
								plev_q <= (op_q == OP_ON) ? PCT_FULL : 7'd0;
								ptgt_q <= (op_q == OP_ON) ? PCT_FULL : 7'd0;
								prem_q <= '0;
								if (op_q == OP_OFF) on_q <= 1'b0;
							end else begin
								pel_q  <= '0;
								ptgt_q <= (op_q == OP_ON) ? PCT_FULL : 7'd0;
								if (cmd_pmag == '0) begin
									prem_q <= '0;
								end else begin
									prem_q     <= dur_q;
									step_pct_q <= 1'b1;
									state_q    <= ST_STEP_WAIT;
								end
							end
						end
						OP_STROBE: begin
							if (!sact_q) begin
								sact_q  <= 1'b1;
								sel_q   <= '0;
								srest_q <= on_q;
							end
							shi_q   <= hi_q;
							slo_q   <= lo_q;
							sleft_q <= rep_q;
							plev_q  <= ptgt_q;
							prem_q  <= '0;
						end
						OP_STOP_STROBE: begin
							if (sact_q) begin
								sact_q  <= 1'b0;
								sleft_q <= '0;
								on_q    <= srest_q;
							end
						end
						default: frem_q <= '0;
					endcase
				end
				ST_STEP_WAIT: begin
					if (drsp.done) begin
						if (step_pct_q) pstep_q <= drsp.quotient[15:0];
						else            fstep_q <= drsp.quotient[15:0];
						state_q <= ST_OUT_MUL;
					end
				end
				// brightness fade step
				ST_FADE_CHK: begin
					state_q <= ST_STROBE;
					if (frem_q != '0 && fel_q >= fstep_q) begin
						if (fel_q >= frem_q) begin
							base_q <= ftgt_q;
							frem_q <= '0;
						end else begin
							state_q <= ST_FADE_GO;
						end
					end
				end
				ST_FADE_GO: state_q <= ST_FADE_WAIT;
				ST_FADE_WAIT: begin
					if (drsp.done) begin
						base_q  <= fnew;
						frem_q  <= frem_q - fel_q;
						fel_q   <= '0;
						state_q <= ST_STROBE;
					end
				end
				// strobe phase
				ST_STROBE: begin
					if (sact_q) begin
						on_q <= ({1'b0, shi_q} > sel_q);
						if (sel_q >= shilo) begin
							sel_q <= '0;
							if (sleft_q != '0) begin
								sleft_q <= sleft_q - 1'b1;
								if (sleft_q == 16'd1) begin
									sact_q  <= 1'b0;
									sleft_q <= '0;
									on_q    <= srest_q;
								end
							end
						end
					end
					state_q <= ST_PCT_CHK;
				end
				// on/off percent fade step
				ST_PCT_CHK: begin
					state_q <= ST_OUT_MUL;
					if (prem_q != '0 && pel_q >= pstep_q) begin
						if (pel_q >= prem_q) begin
							plev_q <= ptgt_q;
							prem_q <= '0;
							if (ptgt_q == '0) on_q <= 1'b0;
						end else begin
							state_q <= ST_PCT_GO;
						end
					end
				end
				ST_PCT_GO: state_q <= ST_PCT_WAIT;
				ST_PCT_WAIT: begin
					if (drsp.done) begin
						plev_q  <= pnew8[6:0];
						prem_q  <= prem_q - pel_q;
						pel_q   <= '0;
						state_q <= ST_OUT_MUL;
					end
				end
				ST_OUT_MUL: state_q <= ST_OUT_GO;
				ST_OUT_GO:  state_q <= ST_OUT_PUT;
				ST_OUT_PUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request capture, shared product and result registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			op_q  <= op;
			lvl_q <= level;
			dur_q <= duration;
			hi_q  <= on_time;
			lo_q  <= off_time;
			rep_q <= repeat_count;
		end
		case (state_q)
			ST_FADE_CHK: prod_q <= 24'(fmag) * 24'(fel_q);
			ST_PCT_CHK:  prod_q <= 24'(pmag) * 24'(pel_q);
			ST_OUT_MUL:  prod_q <= on_q ? 24'(base_q) * 24'(plev_q) : 24'd0;
			default: ;
		endcase
		if (state_q == ST_OUT_GO)
			res_q <= scaled[26:19];
		if (state_q == ST_OUT_PUT && (!out_valid_q || out_ready)) begin
			pwm_q    <= invert_q ? LEVEL_MAX - res_q : res_q;
			lamp_q   <= on_q;
			bright_q <= base_q;
			fading_q <= (frem_q != '0);
			ofad_q   <= (prem_q != '0);
			strb_q   <= sact_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign pwm_level    = pwm_q;
	assign lamp_on      = lamp_q;
	assign brightness   = bright_q;
	assign fading       = fading_q;
	assign onoff_fading = ofad_q;
	assign strobing     = strb_q;

endmodule
